>>> rtl/sdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared types and constants of the stereo doubler delay.
// ----------------------------------------------------------------------------
package sdd_pkg;

    localparam int RING_DEPTH  = 4096;
    localparam int PTR_BITS    = $clog2(RING_DEPTH);
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 8;
    localparam int POS_BITS    = PTR_BITS + FRAC_BITS;

    localparam int DELAY_BITS  = 20;
    localparam int GAIN_BITS   = 16;
    localparam int PAN_BITS    = 17;

    // interpolation sum, one voice after gain, pan products and their sum
    localparam int INTERP_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int VPROD_BITS  = INTERP_BITS + GAIN_BITS + 1;
    localparam int VOICE_BITS  = VPROD_BITS - (FRAC_BITS + 15);
    localparam int PPROD_BITS  = VOICE_BITS + GAIN_BITS + 1;
    localparam int MIX_BITS    = PPROD_BITS + 1;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_DELAY_ONE  = 3'd0;
    localparam t_reg_idx REG_DELAY_TWO  = 3'd1;
    localparam t_reg_idx REG_VOICE_GAIN = 3'd2;
    localparam t_reg_idx REG_PAN_ONE    = 3'd3;
    localparam t_reg_idx REG_PAN_TWO    = 3'd4;

    localparam logic [DELAY_BITS-1:0] DELAY_ONE_RST  = 20'd122880;
    localparam logic [DELAY_BITS-1:0] DELAY_TWO_RST  = 20'd184320;
    localparam logic [GAIN_BITS-1:0]  VOICE_GAIN_RST = 16'd32768;
    localparam logic [PAN_BITS-1:0]   PAN_RST        = 17'd0;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_VOICE1,
        ST_INTERP2,
        ST_VOICE2,
        ST_PAN,
        ST_OUT
    } t_state;

endpackage

>>> rtl/stereo_doubler_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_doubler_delay
// Two-voice fractional delay doubler over a ring of past mono samples.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | left_in, right_in (one stereo pair per item)
//  m_axis    | out       | left_out, right_out (one wet pair per item)
//  apb       | in/out    | delay_one, delay_two, voice_gain, pan_one, pan_two
//
//  from accept until its result is loaded into the output register, an item
//  goes through four ring reads through the single read port, then the
//  chain of interpolation, gain and pan multiplies, each one registered.
//  the input is ready again once the sequencer is back in idle after that
//  load. the ring is not swept at reset: a fill pointer plus a wrapped flag
//  make entries never written read as zero, so items are taken right after
//  reset. a result not taken holds the last step; the next item is accepted
//  while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
module stereo_doubler_delay (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sdd_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [sdd_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [sdd_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [2*sdd_pkg::SAMPLE_BITS-1:0]   s_axis_tdata,   // left_in, right_in
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [2*sdd_pkg::SAMPLE_BITS-1:0]   m_axis_tdata    // left_out, right_out
);
    import sdd_pkg::*;

    // configuration
    logic [DELAY_BITS-1:0]      r_delay_one;
    logic [DELAY_BITS-1:0]      r_delay_two;
    logic [GAIN_BITS-1:0]       r_voice_gain;
    logic signed [PAN_BITS-1:0] r_pan_one;
    logic signed [PAN_BITS-1:0] r_pan_two;

    // sequencer and ring
    t_state                     r_state;
    t_state                     n_state;
    logic [PTR_BITS-1:0]        r_wp;
    logic                       r_full;
    t_sample                    r_ring [RING_DEPTH];
    t_sample                    r_rd_data;
    logic                       r_rd_valid;

    // datapath
    t_sample                         r_mono;
    t_sample                         r_s0;
    t_sample                         r_s1;
    t_sample                         r_s2;
    t_sample                         r_s3;
    logic signed [INTERP_BITS-1:0]   r_interp;
    logic signed [VOICE_BITS-1:0]    r_v1;
    logic signed [VOICE_BITS-1:0]    r_v2;
    logic signed [PPROD_BITS-1:0]    r_pl1;
    logic signed [PPROD_BITS-1:0]    r_pl2;
    logic signed [PPROD_BITS-1:0]    r_pr1;
    logic signed [PPROD_BITS-1:0]    r_pr2;
    logic                            r_out_valid;
    t_sample                         r_left_out;
    t_sample                         r_right_out;

    logic                       w_cfg_wr;
    t_reg_idx                   w_cfg_idx;
    logic                       w_accept;
    logic                       w_load_out;
    logic                       w_advance;
    logic [PTR_BITS-1:0]        w_rd_addr;
    logic                       w_rd_ok;
    t_sample                    w_sample;
    logic [DELAY_BITS-1:0]      w_d1;
    logic [DELAY_BITS-1:0]      w_d2;
    logic [POS_BITS-1:0]        w_pos1;
    logic [POS_BITS-1:0]        w_pos2;
    logic [PTR_BITS-1:0]        w_base1;
    logic [PTR_BITS-1:0]        w_base2;
    logic [FRAC_BITS-1:0]       w_frac1;
    logic [FRAC_BITS-1:0]       w_frac2;
    t_sample                    w_ia;
    t_sample                    w_ib;
    logic [FRAC_BITS-1:0]       w_ifrac;
    logic signed [INTERP_BITS-1:0] w_interp;
    logic signed [VPROD_BITS-1:0]  w_vprod;
    logic signed [VOICE_BITS-1:0]  w_voice;
    logic [GAIN_BITS-1:0]       w_gl1;
    logic [GAIN_BITS-1:0]       w_gl2;
    logic [GAIN_BITS-1:0]       w_gr1;
    logic [GAIN_BITS-1:0]       w_gr2;
    logic signed [MIX_BITS-1:0] w_mix_l;
    logic signed [MIX_BITS-1:0] w_mix_r;
    logic signed [SAMPLE_BITS:0] w_sum;

    // clamp(32768 - pan) or clamp(32768 + pan) into [0, 32768]
    function automatic logic [GAIN_BITS-1:0] pan_gain(
        input logic signed [PAN_BITS-1:0] pan,
        input logic                       plus
    );
        logic signed [PAN_BITS+1:0] d;
        logic signed [PAN_BITS+1:0] unity;
        unity = (PAN_BITS+2)'(32768);
        d = plus ? unity + (PAN_BITS+2)'(pan) : unity - (PAN_BITS+2)'(pan);
        if (d < 0) begin
            pan_gain = '0;
        end else if (d > unity) begin
            pan_gain = unity[GAIN_BITS-1:0];
        end else begin
            pan_gain = d[GAIN_BITS-1:0];
        end
    endfunction

    function automatic t_sample saturate(input logic signed [MIX_BITS-1:0] mix);
        logic signed [MIX_BITS-16:0] q;
        logic signed [MIX_BITS-16:0] hi;
        logic signed [MIX_BITS-16:0] lo;
        q  = (MIX_BITS-15)'((mix + MIX_BITS'(16384)) >>> 15);
        hi = (MIX_BITS-15)'((1 << (SAMPLE_BITS-1)) - 1);
        lo = -hi - (MIX_BITS-15)'(1);
        if (q > hi) begin
            saturate = hi[SAMPLE_BITS-1:0];
        end else if (q < lo) begin
            saturate = lo[SAMPLE_BITS-1:0];
        end else begin
            saturate = q[SAMPLE_BITS-1:0];
        end
    endfunction

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[APB_ADDR_BITS-1:2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_one  <= DELAY_ONE_RST;
            r_delay_two  <= DELAY_TWO_RST;
            r_voice_gain <= VOICE_GAIN_RST;
            r_pan_one    <= PAN_RST;
            r_pan_two    <= PAN_RST;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_DELAY_ONE:  r_delay_one  <= pwdata[DELAY_BITS-1:0];
                REG_DELAY_TWO:  r_delay_two  <= pwdata[DELAY_BITS-1:0];
                REG_VOICE_GAIN: r_voice_gain <= pwdata[GAIN_BITS-1:0];
                REG_PAN_ONE:    r_pan_one    <= pwdata[PAN_BITS-1:0];
                REG_PAN_TWO:    r_pan_two    <= pwdata[PAN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_DELAY_ONE:  prdata = APB_DATA_BITS'(r_delay_one);
            REG_DELAY_TWO:  prdata = APB_DATA_BITS'(r_delay_two);
            REG_VOICE_GAIN: prdata = APB_DATA_BITS'(r_voice_gain);
            REG_PAN_ONE:    prdata = APB_DATA_BITS'(r_pan_one);
            REG_PAN_TWO:    prdata = APB_DATA_BITS'(r_pan_two);
            default:        prdata = '0;
        endcase
    end

    // ---------------- read positions ----------------
    // ring length in fixed point is a power of two, so the wrap is the width
    assign w_d1   = (r_delay_one < DELAY_BITS'(1 << FRAC_BITS)) ?
                    DELAY_BITS'(1 << FRAC_BITS) : r_delay_one;
    assign w_d2   = (r_delay_two < DELAY_BITS'(1 << FRAC_BITS)) ?
                    DELAY_BITS'(1 << FRAC_BITS) : r_delay_two;
    assign w_pos1 = {r_wp, {FRAC_BITS{1'b0}}} - POS_BITS'(w_d1);
    assign w_pos2 = {r_wp, {FRAC_BITS{1'b0}}} - POS_BITS'(w_d2);
    assign w_base1 = w_pos1[POS_BITS-1:FRAC_BITS];
    assign w_base2 = w_pos2[POS_BITS-1:FRAC_BITS];
    assign w_frac1 = w_pos1[FRAC_BITS-1:0];
    assign w_frac2 = w_pos2[FRAC_BITS-1:0];

    // ---------------- sequencer ----------------
    assign s_axis_tready = (r_state == ST_IDLE) & i_rst_n;
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_load_out    = (r_state == ST_OUT) & (~r_out_valid | m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_rd_addr = w_base1;
        w_advance = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_rd_addr = w_base1;
                if (w_accept) begin
                    n_state = ST_RD1;
                end
            end
            ST_RD1: begin
                w_rd_addr = w_base1 + PTR_BITS'(1);
                n_state   = ST_RD2;
            end
            ST_RD2: begin
                w_rd_addr = w_base2;
                n_state   = ST_RD3;
            end
            ST_RD3: begin
                w_rd_addr = w_base2 + PTR_BITS'(1);
                n_state   = ST_VOICE1;
            end
            ST_VOICE1:  n_state = ST_INTERP2;
            ST_INTERP2: n_state = ST_VOICE2;
            ST_VOICE2:  n_state = ST_PAN;
            ST_PAN:     n_state = ST_OUT;
            ST_OUT: begin
                if (w_load_out) begin
                    w_advance = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- ring memory ----------------
    // entries never written since reset read as zero
    assign w_rd_ok  = r_full | (w_rd_addr < r_wp);
    assign w_sample = r_rd_valid ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_ring[w_rd_addr];
        // this item's reads are all done before its mono sample goes in
        if (r_state == ST_VOICE1) begin
            r_ring[r_wp] <= r_mono;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_full     <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_rd_ok;
            if (w_advance) begin
                r_wp <= r_wp + PTR_BITS'(1);
                if (r_wp == PTR_BITS'(RING_DEPTH - 1)) begin
                    r_full <= 1'b1;
                end
            end
        end
    end

    // ---------------- arithmetic ----------------
    assign w_ia    = (r_state == ST_RD3) ? r_s0 : r_s2;
    assign w_ib    = (r_state == ST_RD3) ? r_s1 : r_s3;
    assign w_ifrac = (r_state == ST_RD3) ? w_frac1 : w_frac2;
    assign w_interp =
        INTERP_BITS'(w_ia) * INTERP_BITS'($signed({1'b0, 9'(10'd256 - 10'(w_ifrac))})) +
        INTERP_BITS'(w_ib) * INTERP_BITS'($signed({1'b0, w_ifrac}));

    assign w_vprod = r_interp * $signed({1'b0, r_voice_gain});
    assign w_voice = VOICE_BITS'((w_vprod + VPROD_BITS'(1 << (FRAC_BITS + 14)))
                                 >>> (FRAC_BITS + 15));

    assign w_gl1 = pan_gain(r_pan_one, 1'b0);
    assign w_gl2 = pan_gain(r_pan_two, 1'b0);
    assign w_gr1 = pan_gain(r_pan_one, 1'b1);
    assign w_gr2 = pan_gain(r_pan_two, 1'b1);

    assign w_mix_l = MIX_BITS'(r_pl1) + MIX_BITS'(r_pl2);
    assign w_mix_r = MIX_BITS'(r_pr1) + MIX_BITS'(r_pr2);
    assign w_sum   = (SAMPLE_BITS+1)'($signed(s_axis_tdata[SAMPLE_BITS-1:0])) +
                     (SAMPLE_BITS+1)'($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_mono <= w_sum[SAMPLE_BITS:1];
                end
            end
            ST_RD1:     r_s0 <= w_sample;
            ST_RD2:     r_s1 <= w_sample;
            ST_RD3: begin
                r_s2     <= w_sample;
                r_interp <= w_interp;
            end
            ST_VOICE1: begin
                r_s3 <= w_sample;
                r_v1 <= w_voice;
            end
            ST_INTERP2: r_interp <= w_interp;
            ST_VOICE2:  r_v2 <= w_voice;
            ST_PAN: begin
                r_pl1 <= r_v1 * $signed({1'b0, w_gl1});
                r_pl2 <= r_v2 * $signed({1'b0, w_gl2});
                r_pr1 <= r_v1 * $signed({1'b0, w_gr1});
                r_pr2 <= r_v2 * $signed({1'b0, w_gr2});
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_left_out  <= saturate(w_mix_l);
            r_right_out <= saturate(w_mix_r);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_right_out, r_left_out};

endmodule
